// ----- design/tee_pkg.sv -----
// Shared package of the tree ensemble evaluator: sizes, register indexes,
// controller states and the structs between controller and datapath.
// No dependencies; tee_ctrl, tee_datapath, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package tee_pkg;

  localparam int unsigned MAX_TREES    = 256;
  localparam int unsigned MAX_DEPTH    = 8;
  localparam int unsigned MAX_FEATURES = 256;
  localparam int unsigned MAX_GROUPS   = 64;

  localparam int unsigned TREE_AW        = $clog2(MAX_TREES);
  localparam int unsigned NODE_AW        = MAX_DEPTH;
  localparam int unsigned NODES_PER_TREE = (1 << MAX_DEPTH) - 1;
  localparam int unsigned NODE_MEM_DEPTH = MAX_TREES << MAX_DEPTH;
  localparam int unsigned FEAT_AW        = $clog2(MAX_FEATURES);
  localparam int unsigned GROUP_W        = $clog2(MAX_GROUPS + 1);
  localparam int unsigned LEVEL_W        = $clog2(MAX_DEPTH);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TREE_DEPTH      = 3'd0,
    CFG_TREES_IN_USE    = 3'd1,
    CFG_GROUP_INTERVAL  = 3'd2,
    CFG_LEARNING_RATE   = 3'd3,
    CFG_FEATURES_IN_USE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_NODE,
    ST_EVAL,
    ST_STEP,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tree_number;
    logic [7:0]         node_number;
    logic [7:0]         split_feature;
    logic signed [31:0] split_threshold;
    logic signed [31:0] leaf_value;
    logic signed [31:0] feature_value;
    logic               last_feature;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] prediction;
    logic [5:0]         group_number;
    logic               last_group;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic eval_start;
    logic grp_init;
    logic node_rd;
    logic eval;
    logic step;
    logic acc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_req;
    logic no_group;
    logic empty_single;
    logic lvl_done;
    logic grp_full;
    logic last_grp;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/tee_in_if.sv -----
// Input channel of the tree ensemble evaluator: valid/ready plus item fields.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tee_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         tree_number;
  logic [7:0]         node_number;
  logic [7:0]         split_feature;
  logic signed [31:0] split_threshold;
  logic signed [31:0] leaf_value;
  logic signed [31:0] feature_value;
  logic               last_feature;

  modport source (
    output valid, kind, tree_number, node_number, split_feature,
           split_threshold, leaf_value, feature_value, last_feature,
    input  ready
  );
  modport sink (
    input  valid, kind, tree_number, node_number, split_feature,
           split_threshold, leaf_value, feature_value, last_feature,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/tee_out_if.sv -----
// Result channel of the tree ensemble evaluator: valid/ready plus group sum.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tee_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] prediction;
  logic [5:0]         group_number;
  logic               last_group;

  modport source (
    output valid, prediction, group_number, last_group,
    input  ready
  );
  modport sink (
    input  valid, prediction, group_number, last_group,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/tree_ensemble_evaluator.sv -----
// Top level of the tree ensemble evaluator: channel interfaces, sequencer
// and datapath. Depends on tee_pkg, tee_in_if, tee_out_if, tee_ctrl and
// tee_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in_i   : one transaction per item. kind 0 writes one tree node (split
//            feature, threshold, leaf) into the node memory; kind 1 stores
//            the next sample feature. A feature with last_feature set starts
//            evaluation of the trees in use; a partial last group is skipped.
//   out_o  : one transaction per tree group, groups in order, last_group set
//            on the final one. Sums are Q18.30 and wrap at 48 bits.
//   cfg_*  : register writes, taken at any edge with cfg_we_i high; write
//            only while no evaluation is running.
// Timing
//   Node and feature items are taken one per cycle while idle.
//   Evaluation: each level of a walk goes through node memory read, sample
//   memory read and compare, and each group adds a setup state and a result
//   state. in_i.ready stays low from the triggering feature until the last
//   group is emitted, or until an evaluation with no group returns to idle.
// Reset
//   Configuration returns to its defaults and the feature pointer to zero;
//   node and sample memories keep their contents.
// Backpressure
//   One output register holds a result; when out_o stalls with it full,
//   the walk holds before the next result until the register frees up.

module tree_ensemble_evaluator
  import tee_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  tee_in_if.sink                     in_i,
  tee_out_if.source                  out_o
);

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;
  logic       out_valid;

  // gather the input payload into one struct
  assign in_item.kind            = in_i.kind;
  assign in_item.tree_number     = in_i.tree_number;
  assign in_item.node_number     = in_i.node_number;
  assign in_item.split_feature   = in_i.split_feature;
  assign in_item.split_threshold = in_i.split_threshold;
  assign in_item.leaf_value      = in_i.leaf_value;
  assign in_item.feature_value   = in_i.feature_value;
  assign in_item.last_feature    = in_i.last_feature;
  assign in_i.ready              = in_ready;

  tee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tee_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .sts_o       (sts)
  );

  // drive the result channel from the output register
  assign out_o.valid        = out_valid;
  assign out_o.prediction   = out_item.prediction;
  assign out_o.group_number = out_item.group_number;
  assign out_o.last_group   = out_item.last_group;

endmodule

`default_nettype wire

// ----- design/tee_ctrl.sv -----
// Sequencer of the tree ensemble evaluator: walks groups, trees and levels.
// Depends on tee_pkg for state_e, ctrl_cmd_t and dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module tee_ctrl
  import tee_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.start_req) state_d = ST_GROUP;
      end
      ST_GROUP: begin
        if (sts_i.no_group) begin
          state_d = ST_IDLE;
        end else if (sts_i.empty_single) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_NODE;
        end
      end
      ST_NODE: state_d = ST_EVAL;
      ST_EVAL: state_d = sts_i.lvl_done ? ST_ACC : ST_STEP;
      ST_STEP: state_d = ST_NODE;
      ST_ACC:  state_d = sts_i.grp_full ? ST_EMIT : ST_NODE;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.last_grp ? ST_IDLE : ST_GROUP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.take       = in_valid_i;
        cmd_o.eval_start = in_valid_i && sts_i.start_req;
      end
      ST_GROUP: cmd_o.grp_init = 1'b1;
      ST_NODE:  cmd_o.node_rd  = 1'b1;
      ST_EVAL:  cmd_o.eval     = 1'b1;
      ST_STEP:  cmd_o.step     = 1'b1;
      ST_ACC:   cmd_o.acc      = 1'b1;
      ST_EMIT:  cmd_o.emit     = sts_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/tee_datapath.sv -----
// Datapath of the tree ensemble evaluator: configuration registers, node and
// sample memories, compare, leaf scaling, group accumulator, result register.
// Depends on tee_pkg; driven by tee_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tee_datapath
  import tee_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_item_t              in_item_i,
  input  wire ctrl_cmd_t             cmd_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output out_item_t                  out_item_o,
  output dp_status_t                 sts_o
);

  // configuration registers
  logic [3:0]  tree_depth_q;
  logic [8:0]  trees_in_use_q;
  logic [8:0]  group_interval_q;
  logic [15:0] learning_rate_q;
  logic [8:0]  features_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_depth_q      <= 4'd4;
      trees_in_use_q    <= 9'd1;
      group_interval_q  <= 9'd0;
      learning_rate_q   <= 16'd16384;
      features_in_use_q <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TREE_DEPTH:      tree_depth_q      <= cfg_data_i[3:0];
        CFG_TREES_IN_USE:    trees_in_use_q    <= cfg_data_i[8:0];
        CFG_GROUP_INTERVAL:  group_interval_q  <= cfg_data_i[8:0];
        CFG_LEARNING_RATE:   learning_rate_q   <= cfg_data_i;
        CFG_FEATURES_IN_USE: features_in_use_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // clamped walk length and tree count
  logic [LEVEL_W-1:0] levels_init;
  logic [8:0]         trees_eff;

  always_comb begin
    if (tree_depth_q == 4'd0) begin
      levels_init = '0;
    end else if (tree_depth_q > 4'(MAX_DEPTH)) begin
      levels_init = LEVEL_W'(MAX_DEPTH - 1);
    end else begin
      levels_init = LEVEL_W'(tree_depth_q - 4'd1);
    end
    trees_eff = (trees_in_use_q > 9'(MAX_TREES)) ? 9'(MAX_TREES) : trees_in_use_q;
  end

  // node memory: {split feature, threshold, leaf}, addressed {tree, node}
  logic [71:0]           node_mem [NODE_MEM_DEPTH];
  logic [71:0]           node_rd_q;
  logic                  node_we;
  logic [TREE_AW-1:0]    tree_q, tree_d;
  logic [NODE_AW-1:0]    node_q, node_d;

  assign node_we = cmd_i.take && !in_item_i.kind
                && ({1'b0, in_item_i.tree_number} < 9'(MAX_TREES))
                && ({1'b0, in_item_i.node_number} < 9'(NODES_PER_TREE));

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[{in_item_i.tree_number[TREE_AW-1:0], in_item_i.node_number[NODE_AW-1:0]}]
        <= {in_item_i.split_feature, in_item_i.split_threshold, in_item_i.leaf_value};
    end
    if (cmd_i.node_rd) begin
      node_rd_q <= node_mem[{tree_q, node_q}];
    end
  end

  logic [7:0]         rd_feature;
  logic signed [31:0] rd_threshold;
  logic signed [31:0] rd_leaf;

  assign rd_feature   = node_rd_q[71:64];
  assign rd_threshold = node_rd_q[63:32];
  assign rd_leaf      = node_rd_q[31:0];

  // sample memory with write pointer
  logic [31:0]        feat_mem [MAX_FEATURES];
  logic [31:0]        feat_rd_q;
  logic               feat_ok_q;
  logic [FEAT_AW-1:0] wptr_q, wptr_d;
  logic               feat_we;

  assign feat_we = cmd_i.take && in_item_i.kind;

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[wptr_q] <= in_item_i.feature_value;
    end
    if (cmd_i.eval) begin
      feat_rd_q <= feat_mem[rd_feature[FEAT_AW-1:0]];
      feat_ok_q <= ({1'b0, rd_feature} < features_in_use_q);
    end
  end

  always_comb begin
    wptr_d = wptr_q;
    if (feat_we) begin
      if (in_item_i.last_feature || (wptr_q == FEAT_AW'(MAX_FEATURES - 1))) begin
        wptr_d = '0;
      end else begin
        wptr_d = wptr_q + FEAT_AW'(1);
      end
    end
  end

  // walk, scale and accumulate
  logic [LEVEL_W-1:0] levels_q, levels_d;
  logic [8:0]         trees_left_q, trees_left_d;
  logic [8:0]         grp_cnt_q, grp_cnt_d;
  logic [GROUP_W-1:0] group_q, group_d;
  logic [47:0]        sum_q, sum_d;
  logic [47:0]        prod_q;
  logic signed [48:0] prod_full;
  logic signed [31:0] cmp_x;
  logic               go_left;
  logic               single;

  assign single    = (group_interval_q == 9'd0);
  assign prod_full = rd_leaf * $signed({1'b0, learning_rate_q});
  assign cmp_x     = feat_ok_q ? $signed(feat_rd_q) : 32'sd0;
  assign go_left   = (cmp_x < rd_threshold);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      prod_q <= prod_full[47:0];
    end
  end

  always_comb begin
    tree_d       = tree_q;
    node_d       = node_q;
    levels_d     = levels_q;
    trees_left_d = trees_left_q;
    grp_cnt_d    = grp_cnt_q;
    group_d      = group_q;
    sum_d        = sum_q;
    if (cmd_i.eval_start) begin
      tree_d       = '0;
      group_d      = '0;
      trees_left_d = trees_eff;
    end
    if (cmd_i.grp_init) begin
      sum_d     = '0;
      grp_cnt_d = '0;
      node_d    = '0;
      levels_d  = levels_init;
    end
    if (cmd_i.step) begin
      node_d   = NODE_AW'({node_q, 1'b0} + (go_left ? 9'd1 : 9'd2));
      levels_d = levels_q - LEVEL_W'(1);
    end
    if (cmd_i.acc) begin
      sum_d        = sum_q + prod_q;
      tree_d       = tree_q + TREE_AW'(1);
      trees_left_d = trees_left_q - 9'd1;
      grp_cnt_d    = grp_cnt_q + 9'd1;
      node_d       = '0;
      levels_d     = levels_init;
    end
    if (cmd_i.emit) begin
      group_d = group_q + GROUP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q       <= '0;
      tree_q       <= '0;
      node_q       <= '0;
      levels_q     <= '0;
      trees_left_q <= '0;
      grp_cnt_q    <= '0;
      group_q      <= '0;
      sum_q        <= '0;
    end else begin
      wptr_q       <= wptr_d;
      tree_q       <= tree_d;
      node_q       <= node_d;
      levels_q     <= levels_d;
      trees_left_q <= trees_left_d;
      grp_cnt_q    <= grp_cnt_d;
      group_q      <= group_d;
      sum_q        <= sum_d;
    end
  end

  // result register
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      last_grp;

  assign last_grp = single || (trees_left_q < group_interval_q)
                 || (group_q == GROUP_W'(MAX_GROUPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q.prediction   <= $signed(sum_q);
      out_item_q.group_number <= group_q[5:0];
      out_item_q.last_group   <= last_grp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // status toward the sequencer
  always_comb begin
    sts_o.start_req    = in_item_i.kind && in_item_i.last_feature;
    sts_o.no_group     = !single && ((trees_left_q < group_interval_q)
                       || (group_q == GROUP_W'(MAX_GROUPS)));
    sts_o.empty_single = single && (trees_left_q == 9'd0);
    sts_o.lvl_done     = (levels_q == '0);
    sts_o.grp_full     = single ? (trees_left_q == 9'd1)
                                : ((grp_cnt_q + 9'd1) == group_interval_q);
    sts_o.last_grp     = last_grp;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ----- dv/tb_tree_ensemble_evaluator.sv -----
// Self-checking testbench of the tree ensemble evaluator: loads trees, streams
// samples under idling and backpressure, and checks every group sum in order.
// Depends on tee_pkg, tee_in_if, tee_out_if and tree_ensemble_evaluator.
`timescale 1ns / 1ps

module tb_tree_ensemble_evaluator;
  import tee_pkg::*;

  localparam int unsigned NODE_SLOTS = MAX_TREES * NODES_PER_TREE;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Shadow copy of the evaluator: node and sample stores, registers, and the
  // group sums still owed on the result channel.
  class ensemble_scoreboard;
    logic [7:0]  node_split    [NODE_SLOTS];
    logic [31:0] node_thr      [NODE_SLOTS];
    logic [31:0] node_leaf     [NODE_SLOTS];
    bit          node_loaded   [NODE_SLOTS];
    logic [31:0] sample_val    [MAX_FEATURES];
    bit          sample_loaded [MAX_FEATURES];
    int unsigned feat_ptr;
    logic [3:0]  depth_reg;
    logic [8:0]  trees_reg;
    logic [8:0]  interval_reg;
    logic [15:0] rate_reg;
    logic [8:0]  nfeat_reg;
    out_item_t   pending [$];
    int unsigned issued;
    int unsigned errors;

    function new();
      feat_ptr     = 0;
      depth_reg    = 4'd4;
      trees_reg    = 9'd1;
      interval_reg = 9'd0;
      rate_reg     = 16'd16384;
      nfeat_reg    = 9'd1;
      issued       = 0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TREE_DEPTH:      depth_reg    = val[3:0];
        CFG_TREES_IN_USE:    trees_reg    = val[8:0];
        CFG_GROUP_INTERVAL:  interval_reg = val[8:0];
        CFG_LEARNING_RATE:   rate_reg     = val[15:0];
        CFG_FEATURES_IN_USE: nfeat_reg    = val[8:0];
        default: ;
      endcase
    endfunction

    // Depth 0 acts as a lone root; anything deeper than the store saturates.
    function int unsigned levels();
      if (depth_reg == 0) return 1;
      if (depth_reg > MAX_DEPTH) return MAX_DEPTH;
      return depth_reg;
    endfunction

    function int unsigned trees_used();
      return (trees_reg > MAX_TREES) ? MAX_TREES : trees_reg;
    endfunction

    function logic [31:0] walk(int unsigned tree);
      int unsigned base;
      int unsigned node;
      logic [7:0]  f;
      logic [31:0] x;
      base = tree * NODES_PER_TREE;
      node = 0;
      for (int unsigned lvl = 1; lvl < levels(); lvl++) begin
        f = node_split[base + node];
        // a split on a feature out of use sees zero
        x = (f < nfeat_reg) ? sample_val[f] : '0;
        node = ($signed(x) < $signed(node_thr[base + node])) ? 2 * node + 1 : 2 * node + 2;
      end
      return node_leaf[base + node];
    endfunction

    function void note_item(in_item_t it);
      int unsigned slot;
      int unsigned groups;
      int unsigned used;
      int unsigned grp;
      logic [47:0] sums [MAX_GROUPS];
      logic signed [63:0] term;
      if (!it.kind) begin
        if (it.node_number < NODES_PER_TREE) begin
          slot = it.tree_number * NODES_PER_TREE + it.node_number;
          node_split[slot]  = it.split_feature;
          node_thr[slot]    = it.split_threshold;
          node_leaf[slot]   = it.leaf_value;
          node_loaded[slot] = 1'b1;
        end
        return;
      end
      sample_val[feat_ptr]    = it.feature_value;
      sample_loaded[feat_ptr] = 1'b1;
      feat_ptr = (feat_ptr + 1) % MAX_FEATURES;
      if (!it.last_feature) return;
      feat_ptr = 0;
      if (interval_reg == 0) begin
        groups = 1;
        used   = trees_used();
      end else begin
        groups = trees_used() / interval_reg;
        if (groups > MAX_GROUPS) groups = MAX_GROUPS;
        used = groups * interval_reg;
      end
      for (int unsigned g = 0; g < MAX_GROUPS; g++) sums[g] = '0;
      for (int unsigned t = 0; t < used; t++) begin
        grp  = (interval_reg == 0) ? 0 : t / interval_reg;
        term = $signed(walk(t)) * $signed({1'b0, rate_reg});
        sums[grp] = sums[grp] + term[47:0];
      end
      for (int unsigned g = 0; g < groups; g++) begin
        pending.push_back('{prediction: sums[g], group_number: 6'(g),
                            last_group: (g + 1 == groups)});
        issued++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result prediction %h group %0d last %0b",
                 $time, got.prediction, got.group_number, got.last_group);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.prediction !== want.prediction) begin
        $display("%0t: prediction expected %h actual %h",
                 $time, want.prediction, got.prediction);
        errors++;
      end
      if (got.group_number !== want.group_number) begin
        $display("%0t: group_number expected %0d actual %0d",
                 $time, want.group_number, got.group_number);
        errors++;
      end
      if (got.last_group !== want.last_group) begin
        $display("%0t: last_group expected %0b actual %0b",
                 $time, want.last_group, got.last_group);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tee_in_if  in_ch();
  tee_out_if out_ch();

  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        random_items;
  ensemble_scoreboard sb;

  tree_ensemble_evaluator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly random words, with the signed extremes and small values mixed in
  // so that comparisons land near zero and on the boundaries.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(512) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  // Favor features in use, but let a quarter of the splits point anywhere.
  function automatic logic [7:0] split_pick();
    int unsigned nf;
    nf = sb.nfeat_reg;
    if (nf == 0 || $urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range((nf > MAX_FEATURES) ? MAX_FEATURES - 1 : nf - 1));
  endfunction

  // Node items carry random junk in the feature fields; the block ignores it.
  function automatic in_item_t node_item(int unsigned tree, int unsigned node,
                                         logic [7:0] split, logic [31:0] thr,
                                         logic [31:0] leaf);
    in_item_t it;
    it.kind            = 1'b0;
    it.tree_number     = 8'(tree);
    it.node_number     = 8'(node);
    it.split_feature   = split;
    it.split_threshold = thr;
    it.leaf_value      = leaf;
    it.feature_value   = $urandom;
    it.last_feature    = 1'($urandom_range(1));
    return it;
  endfunction

  // Feature items likewise carry random node fields.
  function automatic in_item_t feature_item(logic [31:0] value, bit last);
    in_item_t it;
    it.kind            = 1'b1;
    it.tree_number     = 8'($urandom_range(255));
    it.node_number     = 8'($urandom_range(255));
    it.split_feature   = 8'($urandom_range(255));
    it.split_threshold = $urandom;
    it.leaf_value      = $urandom;
    it.feature_value   = value;
    it.last_feature    = last;
    return it;
  endfunction

  // Offer one transaction, idling first at the sender rate, and hold it until
  // the block takes it. Valid stays high on return so back-to-back items
  // go out without a gap.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= it.kind;
    in_ch.tree_number     <= it.tree_number;
    in_ch.node_number     <= it.node_number;
    in_ch.split_feature   <= it.split_feature;
    in_ch.split_threshold <= it.split_threshold;
    in_ch.leaf_value      <= it.leaf_value;
    in_ch.feature_value   <= it.feature_value;
    in_ch.last_feature    <= it.last_feature;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  // Drop valid and wait until every owed group sum has been taken.
  task automatic hold_off();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Drain, then give a trigger with no groups time to wind down before any
  // register changes.
  task automatic settle();
    hold_off();
    repeat (16) @(posedge clk);
  endtask

  // Write all five registers back to back, one per edge, while idle.
  task automatic configure(input logic [15:0] depth, input logic [15:0] trees,
                           input logic [15:0] interval, input logic [15:0] rate,
                           input logic [15:0] nfeat);
    cfg_idx_e    regs [5];
    logic [15:0] vals [5];
    regs = '{CFG_TREE_DEPTH, CFG_TREES_IN_USE, CFG_GROUP_INTERVAL,
             CFG_LEARNING_RATE, CFG_FEATURES_IN_USE};
    vals = '{depth, trees, interval, rate, nfeat};
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.set_reg(regs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // Fill every node that a walk of the trees in use could reach, skipping
  // nodes already written by earlier phases.
  task automatic load_trees();
    int unsigned trees;
    int unsigned nodes;
    trees = sb.trees_used();
    nodes = (1 << sb.levels()) - 1;
    for (int unsigned t = 0; t < trees; t++)
      for (int unsigned n = 0; n < nodes; n++)
        if (!sb.node_loaded[t * NODES_PER_TREE + n])
          send(node_item(t, n, split_pick(), pick_word(), pick_word()));
  endtask

  // One sample: mostly exactly the features in use, sometimes short or long,
  // but never so short that a split would read a feature never written.
  // Sprinkle in node rewrites of live trees and writes past the last node.
  task automatic run_sample();
    int unsigned nf;
    int unsigned len;
    int unsigned need;
    nf   = (sb.nfeat_reg > MAX_FEATURES) ? MAX_FEATURES : sb.nfeat_reg;
    need = 0;
    for (int unsigned f = 0; f < nf; f++)
      if (!sb.sample_loaded[f]) need = f + 1;
    len = ($urandom_range(9) < 7) ? nf : $urandom_range(nf + 2, 1);
    if (len < need) len = need;
    if (len == 0) len = 1;
    for (int unsigned k = 0; k < len; k++) begin
      if (sb.trees_used() != 0 && $urandom_range(9) == 0) begin
        send(node_item($urandom_range(sb.trees_used() - 1),
                       $urandom_range((1 << sb.levels()) - 2),
                       split_pick(), pick_word(), pick_word()));
        random_items++;
      end else if ($urandom_range(29) == 0) begin
        send(node_item($urandom_range(255), NODES_PER_TREE, split_pick(),
                       pick_word(), pick_word()));
      end
      send(feature_item(pick_word(), k == len - 1));
      random_items++;
    end
  endtask

  // Reconfigure while idle, pick the idling pattern, load, then stream
  // samples; now and then hold off until every result is back.
  task automatic run_phase(input logic [15:0] depth, input logic [15:0] trees,
                           input logic [15:0] interval, input logic [15:0] rate,
                           input logic [15:0] nfeat, input int unsigned samples,
                           input idle_mode_e mode);
    settle();
    configure(depth, trees, interval, rate, nfeat);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default:       begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
    load_trees();
    for (int unsigned s = 0; s < samples; s++) begin
      run_sample();
      if ($urandom_range(3) == 0) hold_off();
    end
  endtask

  // Result side: check each accepted transaction, then redraw ready.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result('{prediction: out_ch.prediction,
                          group_number: out_ch.group_number,
                          last_group: out_ch.last_group});
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed checks at the reset configuration, fixed corner
  // phases, then random phases until enough items and results have gone by.
  initial begin
    logic [31:0] thr;
    logic [31:0] leaf;
    logic [15:0] depth;
    logic [15:0] trees;
    logic [15:0] interval;
    logic [15:0] rate;
    logic [15:0] nfeat;
    int unsigned lv;
    int unsigned tmax;
    int unsigned p;
    in_item_t    it;

    sb = new;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_TREE_DEPTH;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = 1'b0;
    in_ch.tree_number     = '0;
    in_ch.node_number     = '0;
    in_ch.split_feature   = '0;
    in_ch.split_threshold = '0;
    in_ch.leaf_value      = '0;
    in_ch.feature_value   = '0;
    in_ch.last_feature    = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    random_items          = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tree 0 at the reset depth of four: thresholds at zero, the signed
    // extremes and minus one; some splits on a feature out of use; leaves at
    // the extremes so the scaled sum hits its widest terms.
    for (int unsigned n = 0; n < 15; n++) begin
      case (n % 4)
        0:       thr = 32'h0000_0000;
        1:       thr = 32'h8000_0000;
        2:       thr = 32'h7FFF_FFFF;
        default: thr = 32'hFFFF_FFFF;
      endcase
      case (n % 5)
        0:       leaf = 32'h7FFF_FFFF;
        1:       leaf = 32'h8000_0000;
        2:       leaf = 32'h0000_0000;
        3:       leaf = 32'hFFFF_FFFF;
        default: leaf = 32'h0001_0000;
      endcase
      send(node_item(0, n, (n % 3 == 1) ? 8'hFF : 8'h00, thr, leaf));
    end
    // Node index past the tree is dropped, and a node item flagged last
    // must not start an evaluation.
    it = node_item(MAX_TREES - 1, NODES_PER_TREE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    it.last_feature = 1'b1;
    send(it);
    send(feature_item(32'h8000_0000, 1'b1));
    send(feature_item(32'h7FFF_FFFF, 1'b1));
    send(feature_item(32'h0000_0000, 1'b1));
    send(feature_item(32'hFFFF_FFFF, 1'b1));
    // longer than the features in use: extras land in the store unused
    send(feature_item(32'h0000_0001, 1'b0));
    send(feature_item(32'h8000_0000, 1'b0));
    send(feature_item(32'h7FFF_FFFF, 1'b1));

    // Corners: all 256 trees in one group at full rate; saturated trees with
    // a group per tree capped at the group limit; deepest trees over all
    // features; no trees; fewer trees than one group; splits all out of use
    // with a partial group left over; one group of exactly 256 trees.
    run_phase(1, 256, 0, 16'hFFFF, 4, 2, IDLE_NONE);
    run_phase(0, 511, 1, 16384, 4, 2, IDLE_SENDER);
    run_phase(15, 2, 1, 12345, 256, 1, IDLE_RECEIVER);
    run_phase(3, 0, 0, 16384, 1, 2, IDLE_BOTH);
    run_phase(3, 5, 511, 40000, 511, 1, IDLE_NONE);
    run_phase(2, 7, 3, 0, 0, 3, IDLE_SENDER);
    run_phase(2, 300, 256, 999, 3, 2, IDLE_RECEIVER);

    // Random phases: deep trees stay few so loading stays cheap.
    random_items = 0;
    p = 0;
    while (random_items < 150 || sb.issued < 48) begin
      depth = $urandom_range(15);
      lv    = (depth == 0) ? 1 : (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
      tmax  = (lv <= 2) ? 64 : (lv <= 4) ? 16 : 3;
      trees = $urandom_range(tmax);
      case ($urandom_range(3))
        0:       interval = 0;
        1:       interval = $urandom_range(trees + 1, 1);
        2:       interval = $urandom_range(511);
        default: interval = 1;
      endcase
      if ($urandom_range(3) == 0) rate = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else rate = $urandom_range(65535);
      nfeat = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(12, 1);
      run_phase(depth, trees, interval, rate, nfeat, $urandom_range(6, 3),
                idle_mode_e'(p % 4));
      p++;
    end

    hold_off();
    repeat (32) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tree_ensemble_evaluator: match");
    end else begin
      $display("tree_ensemble_evaluator: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("tree_ensemble_evaluator: mismatch");
    $finish;
  end

endmodule
